FILE: design/btnbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-block search package
// Field widths, register map, request codes and defaults shared by the
// next-block search over the block allocation table.
// ----------------------------------------------------------------------------
package btnbs_pkg;

    localparam int MAX_ENTRIES_DEF  = 1024;
    localparam int SECTOR_SHIFT_DEF = 9;

    localparam int REQ_W    = 1;
    localparam int EIDX_W   = 10;
    localparam int EVAL_W   = 32;
    localparam int OFF_W    = 41;
    localparam int HINT_W   = 11;
    localparam int NBLK_W   = 10;
    localparam int CNT_W    = 11;
    localparam int BSIZE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;
    localparam int MODC_W   = 4;

    localparam logic [REQ_W-1:0]   REQ_LOAD = 1'b0;
    localparam logic [REQ_W-1:0]   REQ_FIND = 1'b1;

    localparam logic               REG_ENTRIES_IN_USE = 1'b0;
    localparam logic               REG_BLOCK_SIZE     = 1'b1;

    localparam logic [EVAL_W-1:0]  UNUSED_MARK     = '1;
    localparam logic [CNT_W-1:0]   ENTRIES_RST     = '0;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 32'd2097152;

endpackage

FILE: design/block_table_next_block_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block table next-block search
// Holds the block allocation table, applies load transactions, and scans
// the entries in use circularly for the nearest block at or past a query.
// ----------------------------------------------------------------------------
// A load or a query scans the n table entries in use, where n is the
// effective entries_in_use (capped at MAX_ENTRIES); a query first forms its
// start index as hint_index mod n by shift-subtract steps, one per hint bit.
// With n = 0 no scan is made. One item is in work at a time. The scan
// reads one table entry a cycle through the memory read port. After reset
// a clearing pass over all MAX_ENTRIES entries marks every entry unused
// before the first item is accepted; configuration writes are taken at once.
module block_table_next_block_search #(
    parameter int MAX_ENTRIES  = btnbs_pkg::MAX_ENTRIES_DEF,
    parameter int SECTOR_SHIFT = btnbs_pkg::SECTOR_SHIFT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btnbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [btnbs_pkg::DATA_W-1:0]   pwdata,
    output logic [btnbs_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [btnbs_pkg::REQ_W-1:0]    req_type,
    input  logic [btnbs_pkg::EIDX_W-1:0]   entry_index,
    input  logic [btnbs_pkg::EVAL_W-1:0]   entry_value,
    input  logic [btnbs_pkg::OFF_W-1:0]    query_offset,
    input  logic [btnbs_pkg::HINT_W-1:0]   hint_index,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [btnbs_pkg::NBLK_W-1:0]   next_block,
    output logic [btnbs_pkg::OFF_W-1:0]    next_offset,
    output logic [btnbs_pkg::CNT_W-1:0]    allocated_count
);

    import btnbs_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int OW = EVAL_W + SECTOR_SHIFT;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   entries_reg;
    logic [BSIZE_W-1:0] bsize_reg;

    logic [EVAL_W-1:0]  mem [MAX_ENTRIES];
    logic [EVAL_W-1:0]  rd_data_reg;

    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CW-1:0]      n_reg, n_next;
    logic               query_reg, query_next;
    logic [OFF_W-1:0]   q_reg, q_next;
    logic [HINT_W-1:0]  hint_reg, hint_next;
    logic [MODC_W-1:0]  modc_reg, modc_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    logic [CW-1:0]      left_reg, left_next;
    logic               proc_vld_reg, proc_vld_next;
    logic [AW-1:0]      proc_idx_reg, proc_idx_next;

    logic               found_reg, found_next;
    logic               stop_reg, stop_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [OW-1:0]      best_off_reg, best_off_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic               found_o_reg, found_o_next;
    logic [NBLK_W-1:0]  nblk_o_reg, nblk_o_next;
    logic [OFF_W-1:0]   noff_o_reg, noff_o_next;
    logic [CNT_W-1:0]   cnt_o_reg, cnt_o_next;

    logic               cfg_we;
    logic [CW-1:0]      n_eff;
    logic               accept;
    logic               load_wr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [EVAL_W-1:0]  mem_wdata;
    logic               rd_en;

    logic [CW:0]        trial;
    logic [CW-1:0]      rem_step;
    logic [AW-1:0]      addr_inc;

    logic               used;
    logic [OW-1:0]      off;
    logic [OW:0]        diff;
    logic               take;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_BLOCK_SIZE)
        begin
            prdata = bsize_reg;
        end
        else
        begin
            prdata = DATA_W'(entries_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RST;
            bsize_reg   <= BLOCK_SIZE_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_ENTRIES_IN_USE)
            begin
                entries_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                bsize_reg <= pwdata[BSIZE_W-1:0];
            end
        end
    end

    assign n_eff = (32'(entries_reg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                         : CW'(entries_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_wr  = accept && (req_type == REQ_LOAD)
                      && (32'(entry_index) < 32'(n_eff));

    assign mem_we    = (state_reg == S_CLEAR) || load_wr;
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : AW'(entry_index);
    assign mem_wdata = (state_reg == S_CLEAR) ? UNUSED_MARK : entry_value;
    assign rd_en     = (state_reg == S_SCAN);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_addr_reg];
        end
    end

    assign trial    = {rem_reg, hint_reg[HINT_W-1]};
    assign rem_step = (trial >= {1'b0, n_reg}) ? CW'(trial - {1'b0, n_reg})
                                               : CW'(trial);
    assign addr_inc = ((CW'(scan_addr_reg) + CW'(1)) == n_reg) ? '0
                                                              : scan_addr_reg + AW'(1);

    assign used = (rd_data_reg != UNUSED_MARK);
    assign off  = OW'(rd_data_reg) << SECTOR_SHIFT;
    assign diff = {1'b0, off} - (OW + 1)'(q_reg);
    assign take = proc_vld_reg && query_reg && used && !stop_reg && !diff[OW]
                  && (!found_reg || (off < best_off_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        n_next         = n_reg;
        query_next     = query_reg;
        q_next         = q_reg;
        hint_next      = hint_reg;
        modc_next      = modc_reg;
        rem_next       = rem_reg;
        scan_addr_next = scan_addr_reg;
        left_next      = left_reg;
        proc_vld_next  = (state_reg == S_SCAN);
        proc_idx_next  = scan_addr_reg;
        found_next     = found_reg;
        stop_next      = stop_reg;
        best_idx_next  = best_idx_reg;
        best_off_next  = best_off_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_o_next   = found_o_reg;
        nblk_o_next    = nblk_o_reg;
        noff_o_next    = noff_o_reg;
        cnt_o_next     = cnt_o_reg;

        if (proc_vld_reg && used)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = proc_idx_reg;
            best_off_next = off;
            if (diff[OW-1:0] < OW'(bsize_reg))
            begin
                stop_next = 1'b1;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next         = n_eff;
                    query_next     = (req_type == REQ_FIND);
                    q_next         = query_offset;
                    hint_next      = hint_index;
                    modc_next      = '0;
                    rem_next       = '0;
                    scan_addr_next = '0;
                    left_next      = n_eff;
                    found_next     = 1'b0;
                    stop_next      = 1'b0;
                    cnt_next       = '0;
                    if (n_eff == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else if (req_type == REQ_FIND)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_MOD:
            begin
                rem_next  = rem_step;
                hint_next = hint_reg << 1;
                modc_next = modc_reg + MODC_W'(1);
                if (modc_reg == MODC_W'(HINT_W - 1))
                begin
                    scan_addr_next = AW'(rem_step);
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_addr_next = addr_inc;
                left_next      = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_o_next   = found_reg;
                    nblk_o_next    = found_reg ? NBLK_W'(best_idx_reg) : '0;
                    noff_o_next    = found_reg ? OFF_W'(best_off_reg) : '0;
                    cnt_o_next     = CNT_W'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            n_reg         <= '0;
            query_reg     <= 1'b0;
            modc_reg      <= '0;
            left_reg      <= '0;
            proc_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            n_reg         <= n_next;
            query_reg     <= query_next;
            modc_reg      <= modc_next;
            left_reg      <= left_next;
            proc_vld_reg  <= proc_vld_next;
            found_reg     <= found_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        hint_reg      <= hint_next;
        rem_reg       <= rem_next;
        scan_addr_reg <= scan_addr_next;
        proc_idx_reg  <= proc_idx_next;
        best_idx_reg  <= best_idx_next;
        best_off_reg  <= best_off_next;
        found_o_reg   <= found_o_next;
        nblk_o_reg    <= nblk_o_next;
        noff_o_reg    <= noff_o_next;
        cnt_o_reg     <= cnt_o_next;
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_o_reg;
    assign next_block      = nblk_o_reg;
    assign next_offset     = noff_o_reg;
    assign allocated_count = cnt_o_reg;

`ifndef SYNTHESIS
    a_stop_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> found_reg)
        else $error("Early exit flagged without a kept entry.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= n_reg)
        else $error("Used-entry count exceeds the entries in use.");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && found_reg |-> (CW'(best_idx_reg) < n_reg))
        else $error("Selected entry lies outside the entries in use.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("Sequencer stayed idle after accepting a transaction.");
`endif

endmodule
